// File: rtl/bcm_pkg.sv
package bcm_pkg;

    localparam int NUM_ENTRIES     = 8;
    localparam int CONDS_PER_ENTRY = 4;

    localparam int ENTRY_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int COND_W  = (CONDS_PER_ENTRY > 1) ? $clog2(CONDS_PER_ENTRY) : 1;

    // control word bit positions
    localparam int CTL_EN   = 0;
    localparam int CTL_ONCE = 1;
    localparam int CTL_OR   = 2;

    typedef enum logic [2:0] {
        OP_EVAL      = 3'd0,
        OP_NOTIFY    = 3'd1,
        OP_CONSUME   = 3'd2,
        OP_WR_COND   = 3'd3,
        OP_WR_CTRL   = 3'd4,
        OP_REMOVE    = 3'd5,
        OP_CLEAR_ALL = 3'd6
    } op_t;

    typedef enum logic [2:0] {
        KIND_NONE  = 3'd0,
        KIND_PC    = 3'd1,
        KIND_REG   = 3'd2,
        KIND_FLAG  = 3'd3,
        KIND_WATCH = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        CMP_EQ = 3'd0,
        CMP_NE = 3'd1,
        CMP_LT = 3'd2,
        CMP_LE = 3'd3,
        CMP_GT = 3'd4,
        CMP_GE = 3'd5
    } cmp_t;

    typedef enum logic [2:0] {
        SEL_A  = 3'd0,
        SEL_X  = 3'd1,
        SEL_Y  = 3'd2,
        SEL_SP = 3'd3,
        SEL_PC = 3'd4
    } reg_sel_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [15:0] pc;
        logic [7:0]  reg_a;
        logic [7:0]  reg_x;
        logic [7:0]  reg_y;
        logic [7:0]  reg_sp;
        logic [6:0]  status_flags;
        logic [15:0] address;
        logic [15:0] value;
        logic [2:0]  entry_index;
        logic [1:0]  cond_index;
        logic [8:0]  settings;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [2:0]  sel;
        logic [2:0]  cmp;
        logic [15:0] operand;
    } cond_t;

    typedef struct packed {
        logic [3:0]  hit_id;
        logic [31:0] hit_count;
        logic        watch_hit;
        logic [15:0] watch_address;
        logic        any_enabled;
        logic        has_watchpoints;
    } result_t;

endpackage

// File: rtl/bcm_cmd_if.sv
interface bcm_cmd_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op;
    logic [15:0] pc;
    logic [7:0]  reg_a;
    logic [7:0]  reg_x;
    logic [7:0]  reg_y;
    logic [7:0]  reg_sp;
    logic [6:0]  status_flags;
    logic [15:0] address;
    logic [15:0] value;
    logic [2:0]  entry_index;
    logic [1:0]  cond_index;
    logic [8:0]  settings;

    modport source (
        output valid, op, pc, reg_a, reg_x, reg_y, reg_sp, status_flags,
               address, value, entry_index, cond_index, settings,
        input  ready
    );

    modport sink (
        input  valid, op, pc, reg_a, reg_x, reg_y, reg_sp, status_flags,
               address, value, entry_index, cond_index, settings,
        output ready
    );
endinterface

// File: rtl/bcm_rsp_if.sv
interface bcm_rsp_if;
    logic        valid;
    logic        ready;
    logic [3:0]  hit_id;
    logic [31:0] hit_count;
    logic        watch_hit;
    logic [15:0] watch_address;
    logic        any_enabled;
    logic        has_watchpoints;

    modport source (
        output valid, hit_id, hit_count, watch_hit, watch_address, any_enabled,
               has_watchpoints,
        input  ready
    );

    modport sink (
        input  valid, hit_id, hit_count, watch_hit, watch_address, any_enabled,
               has_watchpoints,
        output ready
    );
endinterface

// File: rtl/bcm_cmp.sv
module bcm_cmp (
    input  bcm_pkg::cond_t slot,
    input  bcm_pkg::item_t item,
    input  logic           notify_mode,
    input  logic           watch_pending,
    input  logic [15:0]    watch_addr,
    output logic           used,
    output logic           match
);
    import bcm_pkg::*;

    logic [15:0] lhs;
    logic [2:0]  how;
    logic        gate;
    logic        cmp_res;
    logic [7:0]  flags_ext;

    assign flags_ext = {1'b0, item.status_flags};

    assign used = (slot.kind == KIND_PC) || (slot.kind == KIND_REG) ||
                  (slot.kind == KIND_FLAG) || (slot.kind == KIND_WATCH);

    // operand steering into the one comparator
    always_comb
    begin
        lhs  = '0;
        how  = CMP_EQ;
        gate = 1'b0;
        if (notify_mode)
        begin
            lhs  = item.address;
            gate = (slot.kind == KIND_WATCH);
        end
        else
        begin
            case (slot.kind)
                KIND_PC:
                begin
                    lhs  = item.pc;
                    gate = 1'b1;
                end
                KIND_REG:
                begin
                    how  = slot.cmp;
                    gate = 1'b1;
                    case (slot.sel)
                        SEL_A:   lhs = {8'd0, item.reg_a};
                        SEL_X:   lhs = {8'd0, item.reg_x};
                        SEL_Y:   lhs = {8'd0, item.reg_y};
                        SEL_SP:  lhs = {8'd0, item.reg_sp};
                        SEL_PC:  lhs = item.pc;
                        default: lhs = '0;
                    endcase
                end
                KIND_FLAG:
                begin
                    // select seven reads the padding bit, i.e. zero
                    how  = slot.cmp;
                    gate = 1'b1;
                    lhs  = {15'd0, flags_ext[slot.sel]};
                end
                KIND_WATCH:
                begin
                    lhs  = watch_addr;
                    gate = watch_pending;
                end
                default:
                begin
                    gate = 1'b0;
                end
            endcase
        end
    end

    always_comb
    begin
        case (how)
            CMP_EQ:  cmp_res = (lhs == slot.operand);
            CMP_NE:  cmp_res = (lhs != slot.operand);
            CMP_LT:  cmp_res = (lhs <  slot.operand);
            CMP_LE:  cmp_res = (lhs <= slot.operand);
            CMP_GT:  cmp_res = (lhs >  slot.operand);
            CMP_GE:  cmp_res = (lhs >= slot.operand);
            default: cmp_res = 1'b0;
        endcase
    end

    assign match = gate && cmp_res;

endmodule

// File: rtl/bcm_ctrl.sv
module bcm_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  bcm_pkg::item_t   cmd_item,
    output logic             cmd_ready,
    input  logic             res_ready,
    output logic             res_valid,
    output bcm_pkg::result_t res
);
    import bcm_pkg::*;

    state_t state_reg, state_next;
    item_t  item_reg, item_next;

    logic [2:0]  kind_reg [NUM_ENTRIES][CONDS_PER_ENTRY];
    logic [2:0]  kind_next [NUM_ENTRIES][CONDS_PER_ENTRY];
    logic [2:0]  sel_reg [NUM_ENTRIES][CONDS_PER_ENTRY];
    logic [2:0]  sel_next [NUM_ENTRIES][CONDS_PER_ENTRY];
    logic [2:0]  cmpop_reg [NUM_ENTRIES][CONDS_PER_ENTRY];
    logic [2:0]  cmpop_next [NUM_ENTRIES][CONDS_PER_ENTRY];
    logic [15:0] opnd_reg [NUM_ENTRIES][CONDS_PER_ENTRY];
    logic [15:0] opnd_next [NUM_ENTRIES][CONDS_PER_ENTRY];
    logic [2:0]  ctl_reg [NUM_ENTRIES];
    logic [2:0]  ctl_next [NUM_ENTRIES];
    logic [31:0] cnt_reg [NUM_ENTRIES];
    logic [31:0] cnt_next [NUM_ENTRIES];

    logic        pend_reg, pend_next;
    logic [15:0] waddr_reg, waddr_next;

    logic [ENTRY_W-1:0] e_reg, e_next;
    logic [COND_W-1:0]  k_reg, k_next;
    logic               used_reg, used_next;
    logic               res_reg, res_next;

    logic [3:0]  hid_reg, hid_next;
    logic [31:0] hcnt_reg, hcnt_next;
    logic        wh_reg, wh_next;
    logic [15:0] wa_reg, wa_next;

    cond_t              slot;
    logic               slot_used;
    logic               slot_match;
    logic               is_eval;
    logic               en, orm;
    logic               base_used, base_res;
    logic               step_used, step_res;
    logic               k_last, e_last;
    logic               scan_hit, scan_done;
    logic [31:0]        cnt_inc;
    logic               ei_ok, ci_ok;
    logic [ENTRY_W-1:0] ei;
    logic [COND_W-1:0]  ci;
    logic               any_en, has_watch;

    assign slot = '{kind: kind_reg[e_reg][k_reg], sel: sel_reg[e_reg][k_reg],
                    cmp: cmpop_reg[e_reg][k_reg], operand: opnd_reg[e_reg][k_reg]};

    assign is_eval = (item_reg.op == OP_EVAL);

    bcm_cmp u_cmp (
        .slot          (slot),
        .item          (item_reg),
        .notify_mode   (!is_eval),
        .watch_pending (pend_reg),
        .watch_addr    (waddr_reg),
        .used          (slot_used),
        .match         (slot_match)
    );

    // per-slot scan step
    assign en        = ctl_reg[e_reg][CTL_EN];
    assign orm       = ctl_reg[e_reg][CTL_OR];
    assign base_used = (k_reg == '0) ? 1'b0 : used_reg;
    assign base_res  = (k_reg == '0) ? !orm : res_reg;
    assign step_used = base_used || slot_used;
    assign k_last    = (k_reg == COND_W'(CONDS_PER_ENTRY - 1));
    assign e_last    = (e_reg == ENTRY_W'(NUM_ENTRIES - 1));
    assign cnt_inc   = cnt_reg[e_reg] + 32'd1;

    always_comb
    begin
        step_res = base_res;
        if (slot_used)
        begin
            if (orm && slot_match)
                step_res = 1'b1;
            else if (!orm && !slot_match)
                step_res = 1'b0;
        end
    end

    assign scan_hit  = is_eval ? (en && k_last && step_used && step_res)
                               : (en && slot_match);
    assign scan_done = scan_hit || (k_last && e_last);

    assign ei_ok = (32'(item_reg.entry_index) < 32'(NUM_ENTRIES));
    assign ci_ok = (32'(item_reg.cond_index) < 32'(CONDS_PER_ENTRY));
    assign ei    = ENTRY_W'(item_reg.entry_index);
    assign ci    = COND_W'(item_reg.cond_index);

    // status flags from settled state
    always_comb
    begin
        any_en    = 1'b0;
        has_watch = 1'b0;
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            any_en = any_en | ctl_reg[e][CTL_EN];
            for (int k = 0; k < CONDS_PER_ENTRY; k++)
                has_watch = has_watch |
                            (ctl_reg[e][CTL_EN] && (kind_reg[e][k] == KIND_WATCH));
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                    state_next = ST_EXEC;
            ST_EXEC:
                if (item_reg.op == OP_EVAL || item_reg.op == OP_NOTIFY)
                    state_next = ST_SCAN;
                else
                    state_next = ST_FIN;
            ST_SCAN:
                if (scan_done)
                    state_next = ST_FIN;
            ST_FIN:
                if (res_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        res_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: cmd_ready = 1'b1;
            ST_FIN:  res_valid = res_ready;
            default:
            begin
                cmd_ready = 1'b0;
                res_valid = 1'b0;
            end
        endcase
    end

    assign res = '{hit_id: hid_reg, hit_count: hcnt_reg, watch_hit: wh_reg,
                   watch_address: wa_reg, any_enabled: any_en,
                   has_watchpoints: has_watch};

    // datapath and table updates
    always_comb
    begin
        item_next  = item_reg;
        kind_next  = kind_reg;
        sel_next   = sel_reg;
        cmpop_next = cmpop_reg;
        opnd_next  = opnd_reg;
        ctl_next   = ctl_reg;
        cnt_next   = cnt_reg;
        pend_next  = pend_reg;
        waddr_next = waddr_reg;
        e_next     = e_reg;
        k_next     = k_reg;
        used_next  = used_reg;
        res_next   = res_reg;
        hid_next   = hid_reg;
        hcnt_next  = hcnt_reg;
        wh_next    = wh_reg;
        wa_next    = wa_reg;

        unique case (state_reg)
            ST_IDLE:
                if (cmd_valid)
                    item_next = cmd_item;
            ST_EXEC:
            begin
                e_next    = '0;
                k_next    = '0;
                hid_next  = '0;
                hcnt_next = '0;
                wh_next   = 1'b0;
                wa_next   = '0;
                unique case (item_reg.op)
                    OP_CONSUME:
                        if (pend_reg)
                        begin
                            wh_next   = 1'b1;
                            wa_next   = waddr_reg;
                            pend_next = 1'b0;
                        end
                    OP_WR_COND:
                        if (ei_ok && ci_ok)
                        begin
                            kind_next[ei][ci]  = item_reg.settings[2:0];
                            sel_next[ei][ci]   = item_reg.settings[5:3];
                            cmpop_next[ei][ci] = item_reg.settings[8:6];
                            if (item_reg.settings[2:0] == KIND_REG ||
                                item_reg.settings[2:0] == KIND_FLAG)
                                opnd_next[ei][ci] = item_reg.value;
                            else
                                opnd_next[ei][ci] = item_reg.address;
                        end
                    OP_WR_CTRL:
                        if (ei_ok)
                            ctl_next[ei] = item_reg.settings[2:0];
                    OP_REMOVE:
                        if (ei_ok)
                        begin
                            for (int k = 0; k < CONDS_PER_ENTRY; k++)
                                kind_next[ei][k] = KIND_NONE;
                            ctl_next[ei] = '0;
                            cnt_next[ei] = '0;
                        end
                    OP_CLEAR_ALL:
                    begin
                        for (int e = 0; e < NUM_ENTRIES; e++)
                        begin
                            for (int k = 0; k < CONDS_PER_ENTRY; k++)
                                kind_next[e][k] = KIND_NONE;
                            ctl_next[e] = '0;
                            cnt_next[e] = '0;
                        end
                        pend_next = 1'b0;
                    end
                    default:
                    begin
                        pend_next = pend_reg;
                    end
                endcase
            end
            ST_SCAN:
            begin
                used_next = step_used;
                res_next  = step_res;
                if (scan_hit)
                begin
                    if (is_eval)
                    begin
                        cnt_next[e_reg] = cnt_inc;
                        hcnt_next       = cnt_inc;
                        hid_next        = 4'(32'(e_reg) + 32'd1);
                        if (ctl_reg[e_reg][CTL_ONCE])
                            ctl_next[e_reg][CTL_EN] = 1'b0;
                    end
                    else
                    begin
                        waddr_next = item_reg.address;
                        pend_next  = 1'b1;
                    end
                end
                else if (!k_last)
                    k_next = k_reg + 1'b1;
                else if (!e_last)
                begin
                    k_next = '0;
                    e_next = e_reg + 1'b1;
                end
            end
            ST_FIN:
            begin
                item_next = item_reg;
            end
            default:
            begin
                item_next = item_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b0;
            waddr_reg <= '0;
            for (int e = 0; e < NUM_ENTRIES; e++)
            begin
                ctl_reg[e] <= '0;
                cnt_reg[e] <= '0;
                for (int k = 0; k < CONDS_PER_ENTRY; k++)
                    kind_reg[e][k] <= KIND_NONE;
            end
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            waddr_reg <= waddr_next;
            ctl_reg   <= ctl_next;
            cnt_reg   <= cnt_next;
            kind_reg  <= kind_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg  <= item_next;
        sel_reg   <= sel_next;
        cmpop_reg <= cmpop_next;
        opnd_reg  <= opnd_next;
        e_reg     <= e_next;
        k_reg     <= k_next;
        used_reg  <= used_next;
        res_reg   <= res_next;
        hid_reg   <= hid_next;
        hcnt_reg  <= hcnt_next;
        wh_reg    <= wh_next;
        wa_reg    <= wa_next;
    end

    // a nonzero hit id only comes out of an evaluate scan
    a_hit_only_eval: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (hid_reg != 4'd0) |-> (item_reg.op == OP_EVAL))
        else $error("hit id reported for a non-evaluate transaction");

    // watch hit only reported by consume
    a_watch_only_consume: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && wh_reg |-> (item_reg.op == OP_CONSUME))
        else $error("watch hit reported for a non-consume transaction");

    // consume always leaves the pending watch cleared
    a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && (item_reg.op == OP_CONSUME) |=> !pend_reg)
        else $error("pending watch survived a consume");

    // scan pointer stays inside the table
    a_scan_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (32'(e_reg) < 32'(NUM_ENTRIES)))
        else $error("scan entry pointer out of range");

endmodule

// File: rtl/breakpoint_condition_matcher.sv
// breakpoint / watchpoint trigger unit for a 6502-class cpu debugger. a table of
// 8 entries with 4 condition slots each (pc match, register or flag compare,
// write watch), a control word per entry (enable, hit-once, or-mode) and a
// 32-bit hit counter. each cmd transaction carries one command and returns
// exactly one rsp transaction; any_enabled and has_watchpoints always reflect
// the table after that command. evaluate and write-notify walk the slots one
// per cycle through a single shared comparator, in slot order, and stop at
// the first hit or after all 32 slots. each command goes from idle to a setup
// state, then to the slot scan (evaluate and write-notify only), then to a
// result state that waits until the rsp output register is free, and back to
// idle. the unit accepts one command at a time; a finished response sits in
// the rsp output register, so the next command can be taken while it waits.
// a clear-all keeps the last watch address but drops the pending watch hit.
module breakpoint_condition_matcher (
    input logic      clk,
    input logic      rst_n,
    bcm_cmd_if.sink  cmd,
    bcm_rsp_if.source rsp
);
    import bcm_pkg::*;

    item_t   cmd_item;
    result_t res;
    logic    res_valid;
    logic    res_ready;
    logic    ctrl_ready;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;

    // pack the command transaction for the sequencer
    assign cmd_item = '{op: cmd.op, pc: cmd.pc, reg_a: cmd.reg_a, reg_x: cmd.reg_x,
                        reg_y: cmd.reg_y, reg_sp: cmd.reg_sp,
                        status_flags: cmd.status_flags, address: cmd.address,
                        value: cmd.value, entry_index: cmd.entry_index,
                        cond_index: cmd.cond_index, settings: cmd.settings};

    assign cmd.ready = ctrl_ready;

    // output register is free when empty or being drained this cycle
    assign res_ready = !out_valid_reg || rsp.ready;

    bcm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_item  (cmd_item),
        .cmd_ready (ctrl_ready),
        .res_ready (res_ready),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (res_valid)
        begin
            out_valid_next = 1'b1;
            out_next       = res;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.hit_id          = out_reg.hit_id;
    assign rsp.hit_count       = out_reg.hit_count;
    assign rsp.watch_hit       = out_reg.watch_hit;
    assign rsp.watch_address   = out_reg.watch_address;
    assign rsp.any_enabled     = out_reg.any_enabled;
    assign rsp.has_watchpoints = out_reg.has_watchpoints;

endmodule
